>>> design/cache_key_allocator_macros.svh
// ---------------------------------------------------------------------------
// cache key allocator assertion macros
// concurrent assertion shorthands used by the checker file
// ---------------------------------------------------------------------------
`ifndef CACHE_KEY_ALLOCATOR_MACROS_SVH
`define CACHE_KEY_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define CKA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CKA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/cka_pkg.sv
// ---------------------------------------------------------------------------
// cache key allocator package
// sizes, status codes and the control/status bundles between fsm and datapath
// ---------------------------------------------------------------------------
package cka_pkg;

  localparam int NUM_KEYS    = 255;
  localparam int COUNT_WIDTH = 8;
  localparam int KEY_W       = 8;
  localparam int IDX_W       = $clog2(NUM_KEYS);
  localparam int KEY_CMP_W   = (IDX_W > KEY_W) ? IDX_W : KEY_W;

  // mark scan: groups of GRP_W marks, padded so at least one pad bit exists
  localparam int GRP_W      = 16;
  localparam int GRP_POS_W  = $clog2(GRP_W);
  localparam int NUM_GRP    = NUM_KEYS / GRP_W + 1;
  localparam int GRP_SEL_W  = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
  localparam int NUM_GRP_P  = 1 << GRP_SEL_W;
  localparam int PAD_W      = NUM_GRP_P * GRP_W;

  localparam int MEM_AW     = IDX_W + 1;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  typedef logic [2:0] cka_status_t;

  localparam cka_status_t ST_OK             = 3'd0;
  localparam cka_status_t ST_NO_KEY         = 3'd1;
  localparam cka_status_t ST_CODE_UNDERFLOW = 3'd2;
  localparam cka_status_t ST_DATA_NONZERO   = 3'd3;
  localparam cka_status_t ST_INVALID        = 3'd4;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;
  localparam logic POOL_CODE  = 1'b0;
  localparam logic POOL_DATA  = 1'b1;

  typedef struct packed {
    logic latch_in;
    logic scan_grp;
    logic scan_pick;
    logic rebuild;
    logic commit;
    logic no_key;
    logic rd;
    logic upd;
    logic out_load;
  } cka_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic found;
    logic purged;
  } cka_sts_t;

  // position of the lowest clear bit, GRP_W-1 when none is clear
  function automatic logic [GRP_POS_W-1:0] lowest_zero(input logic [GRP_W-1:0] v);
    logic [GRP_POS_W-1:0] pos;
    pos = GRP_POS_W'(GRP_W - 1);
    for (int i = GRP_W - 1; i >= 0; i--) begin
      if (!v[i]) pos = GRP_POS_W'(i);
    end
    return pos;
  endfunction

endpackage

>>> design/cka_ctrl.sv
// ---------------------------------------------------------------------------
// cache key allocator controller
// sequences scan, purge retry, count update and result hand-off
// ---------------------------------------------------------------------------
module cka_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  cka_pkg::cka_sts_t sts,
  output cka_pkg::cka_cmd_t cmd
);
  import cka_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_GRP  = 7'b0000010,
    S_PICK = 7'b0000100,
    S_EVAL = 7'b0001000,
    S_RD   = 7'b0010000,
    S_UPD  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_GRP;
        end
      end
      S_GRP: begin
        cmd.scan_grp = 1'b1;
        state_nxt    = S_PICK;
      end
      S_PICK: begin
        cmd.scan_pick = 1'b1;
        state_nxt     = S_EVAL;
      end
      S_EVAL: begin
        if (sts.found) begin
          cmd.commit = 1'b1;
          state_nxt  = S_DONE;
        end else if (!sts.purged) begin
          // purge: marks follow the live counts, then scan again
          cmd.rebuild = 1'b1;
          state_nxt   = S_GRP;
        end else begin
          cmd.no_key = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // release requests skip the scan
    if (state_r == S_GRP && !sts.is_alloc) begin
      cmd.scan_grp = 1'b0;
      state_nxt    = S_RD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> design/cka_dp.sv
// ---------------------------------------------------------------------------
// cache key allocator datapath
// mark and nonzero vectors, count memory, two-level mark scan, result regs
// ---------------------------------------------------------------------------
module cka_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [cka_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic [cka_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  cka_pkg::cka_cmd_t                  cmd,
  output cka_pkg::cka_sts_t                  sts
);
  import cka_pkg::*;

  logic                   op_r;
  logic                   pool_r;
  logic [KEY_W-1:0]       key_r;

  logic [NUM_KEYS-1:0]    mark_r [0:1];
  // nz_r mirrors count != 0 so a purge rebuild is a single copy
  logic [NUM_KEYS-1:0]    nz_r   [0:1];

  logic [COUNT_WIDTH-1:0] cnt_mem [0:(1 << MEM_AW)-1];
  logic [COUNT_WIDTH-1:0] rdata_r;

  logic [NUM_GRP_P-1:0]   grp_any_r;
  logic                   found_r;
  logic [IDX_W-1:0]       pick_r;

  logic [KEY_W-1:0]       res_key_r;
  logic                   res_purge_r;
  cka_status_t            res_status_r;
  logic [KEY_W-1:0]       out_key_r;
  logic                   out_purge_r;
  cka_status_t            out_status_r;

  logic [PAD_W-1:0]       mark_pad;
  logic [GRP_SEL_W-1:0]   grp_sel;
  logic [GRP_W-1:0]       grp_bits;
  logic [GRP_POS_W-1:0]   grp_pos;

  logic [KEY_CMP_W-1:0]   key_ext;
  logic                   key_bad;
  logic [IDX_W-1:0]       rel_idx;
  logic [COUNT_WIDTH-1:0] cur_cnt;
  logic [COUNT_WIDTH-1:0] dec_cnt;
  logic [IDX_W:0]         key_num;

  logic                   wr_en;
  logic [MEM_AW-1:0]      wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;

  // unused pad positions read as marked so they are never picked
  assign mark_pad = {{(PAD_W - NUM_KEYS){1'b1}}, mark_r[pool_r]};

  always_comb begin
    grp_sel = GRP_SEL_W'(NUM_GRP_P - 1);
    for (int g = NUM_GRP_P - 1; g >= 0; g--) begin
      if (grp_any_r[g]) grp_sel = GRP_SEL_W'(g);
    end
  end

  assign grp_bits = mark_pad[grp_sel * GRP_W +: GRP_W];
  assign grp_pos  = lowest_zero(grp_bits);

  assign key_ext = KEY_CMP_W'(key_r);
  assign key_bad = (key_r == '0) || (key_ext > KEY_CMP_W'(NUM_KEYS));
  assign rel_idx = IDX_W'(key_ext - KEY_CMP_W'(1));
  assign cur_cnt = nz_r[pool_r][rel_idx] ? rdata_r : '0;
  assign dec_cnt = cur_cnt - COUNT_WIDTH'(1);
  assign key_num = {1'b0, pick_r} + (IDX_W + 1)'(1);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {pool_r, pick_r};
    wr_data = COUNT_WIDTH'(1);
    if (cmd.commit) begin
      wr_en = 1'b1;
    end else if (cmd.upd && !key_bad && (cur_cnt != '0)) begin
      wr_en   = 1'b1;
      wr_addr = {pool_r, rel_idx};
      wr_data = dec_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) cnt_mem[wr_addr] <= wr_data;
    if (cmd.rd) rdata_r <= cnt_mem[{pool_r, rel_idx}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r[0] <= '0;
      mark_r[1] <= '0;
      nz_r[0]   <= '0;
      nz_r[1]   <= '0;
    end else begin
      if (cmd.rebuild) mark_r[pool_r] <= nz_r[pool_r];
      if (cmd.commit) begin
        mark_r[pool_r][pick_r] <= 1'b1;
        nz_r[pool_r][pick_r]   <= 1'b1;
      end
      if (cmd.upd && !key_bad && (cur_cnt != '0)) begin
        nz_r[pool_r][rel_idx] <= (dec_cnt != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r         <= in_tdata[0];
      pool_r       <= in_tdata[1];
      key_r        <= in_tdata[KEY_W+1:2];
      res_key_r    <= '0;
      res_purge_r  <= 1'b0;
      res_status_r <= ST_OK;
    end
    if (cmd.scan_grp) begin
      for (int g = 0; g < NUM_GRP_P; g++) begin
        grp_any_r[g] <= ~&mark_pad[g * GRP_W +: GRP_W];
      end
    end
    if (cmd.scan_pick) begin
      found_r <= |grp_any_r;
      pick_r  <= IDX_W'({grp_sel, grp_pos});
    end
    if (cmd.rebuild) res_purge_r <= 1'b1;
    if (cmd.commit) res_key_r <= KEY_W'(key_num);
    if (cmd.no_key) res_status_r <= ST_NO_KEY;
    if (cmd.upd) begin
      if (key_bad) begin
        res_status_r <= ST_INVALID;
      end else if (cur_cnt == '0) begin
        res_status_r <= (pool_r == POOL_DATA) ? ST_DATA_NONZERO : ST_CODE_UNDERFLOW;
      end else if ((pool_r == POOL_DATA) && (dec_cnt != '0)) begin
        res_status_r <= ST_DATA_NONZERO;
      end
    end
    if (cmd.out_load) begin
      out_key_r    <= res_key_r;
      out_purge_r  <= res_purge_r;
      out_status_r <= res_status_r;
    end
  end

  assign sts.is_alloc = (op_r == OP_ALLOC);
  assign sts.found    = found_r;
  assign sts.purged   = res_purge_r;

  assign out_tdata = {{(OUT_TDATA_W - KEY_W - 4){1'b0}}, out_status_r, out_purge_r, out_key_r};

endmodule

>>> design/cache_key_allocator.sv
// ---------------------------------------------------------------------------
// cache key allocator
// hands out and releases code/data cache keys with purge-and-retry on exhaustion
// ---------------------------------------------------------------------------
// channel | dir | bus                   | contents
// in_     | in  | tvalid/tready/tdata16 | op, pool, key_in
// out_    | out | tvalid/tready/tdata16 | key_out, purge_request, status
//
// allocate: from accept through the two-stage registered scan over the marks
// (group, pick), evaluate, commit and hand-off; a purge rebuilds the marks and
// repeats the scan. release: skips the scan and goes through the registered read
// of the count memory, the count update and hand-off. reset clears marks and
// nonzero bits; counts behind a clear nonzero bit read as zero. a stalled result holds the next one in the fsm
// ---------------------------------------------------------------------------
module cache_key_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [cka_pkg::IN_TDATA_W-1:0]  in_tdata,   // op, pool, key_in[7:0], zero pad
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [cka_pkg::OUT_TDATA_W-1:0] out_tdata   // key_out[7:0], purge_request,
                                                      // status[2:0], zero pad
);
  import cka_pkg::*;

  cka_cmd_t cmd;
  cka_sts_t sts;

  cka_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  cka_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

>>> design/cka_checker.sv
// ---------------------------------------------------------------------------
// cache key allocator checker
// port-level properties of the request and result streams, bound to the top level
// ---------------------------------------------------------------------------
`include "cache_key_allocator_macros.svh"

module cka_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [cka_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import cka_pkg::*;

  logic [KEY_W-1:0] key_f;
  logic             purge_f;
  cka_status_t      status_f;

  assign key_f    = out_tdata[KEY_W-1:0];
  assign purge_f  = out_tdata[KEY_W];
  assign status_f = out_tdata[KEY_W+3:KEY_W+1];

  `CKA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `CKA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "new request taken during work")
  `CKA_ASSERT_NOW(a_purge_alloc_only, clk, rst_n, out_tvalid && purge_f, status_f == ST_OK || status_f == ST_NO_KEY, "purge on a release")
  `CKA_ASSERT_NOW(a_error_no_key, clk, rst_n, out_tvalid && status_f != ST_OK, key_f == '0, "key granted with error status")
  `CKA_ASSERT_NOW(a_no_key_purged, clk, rst_n, out_tvalid && status_f == ST_NO_KEY, purge_f, "no key without purge")

endmodule

bind cache_key_allocator cka_checker u_cka_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
